@@ src/clnwq_pkg.sv @@
// Package for the character-LCD nibble write queue.
// Holds the item types, register layout and command codes; no dependencies.
package clnwq_pkg;

  // One input item: a tick or an enqueue of a display write.
  typedef struct packed {
    logic       command;
    logic [7:0] byte_value;
    logic       is_data;
  } in_item_t;

  // One result item: pin levels and ring status.
  typedef struct packed {
    logic       reg_select;
    logic       enable_pin;
    logic [3:0] data_nibble;
    logic       dropped;
    logic [4:0] pending_count;
  } out_item_t;

  // One ring entry: the flag in the top bit, the byte below it.
  typedef struct packed {
    logic       is_data;
    logic [7:0] byte_value;
  } ring_entry_t;

  localparam int ENTRY_W = $bits(ring_entry_t);

  // An item after classification by the front part.
  typedef struct packed {
    logic        is_enqueue;
    ring_entry_t entry;
  } work_item_t;

  // Configuration register values.
  typedef struct packed {
    logic [3:0] pulse_wait_ticks;
    logic [3:0] slow_command_wait_ticks;
  } cfg_t;

  localparam logic       CMD_TICK    = 1'b0;
  localparam logic       CMD_ENQUEUE = 1'b1;

  localparam logic       REG_PULSE_WAIT = 1'b0;
  localparam logic       REG_SLOW_WAIT  = 1'b1;

  localparam logic [3:0] PULSE_WAIT_RESET = 4'd1;
  localparam logic [3:0] SLOW_WAIT_RESET  = 4'd2;

  localparam logic [7:0] LCD_CLEAR = 8'h01;
  localparam logic [7:0] LCD_HOME  = 8'h02;

endpackage

@@ src/clnwq_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module clnwq_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ src/clnwq_front.sv @@
// Front part: accepts input items, classifies them and holds them in a
// two-entry queue for the back part. Depends on clnwq_pkg.
module clnwq_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  clnwq_pkg::in_item_t  item,
  output logic                 work_valid,
  input  logic                 work_ready,
  output clnwq_pkg::work_item_t work
);
  import clnwq_pkg::*;

  work_item_t slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  work_item_t classified;

  always_comb begin
    classified.is_enqueue       = (item.command == CMD_ENQUEUE);
    classified.entry.is_data    = item.is_data;
    classified.entry.byte_value = item.byte_value;
  end

  assign item_ready = (count != 2'd2);
  assign work_valid = (count != 2'd0);
  assign work       = slot[rd_ptr];
  assign push       = item_valid && item_ready;
  assign pop        = work_valid && work_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= classified;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

@@ src/clnwq_back.sv @@
// Back part: runs the write ring and the nibble sequencer into a result
// register, one item per unstalled cycle. Depends on clnwq_pkg and clnwq_ram.
module clnwq_back #(
  parameter int RING_ENTRIES = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  clnwq_pkg::cfg_t       cfg,
  input  logic                  work_valid,
  output logic                  work_ready,
  input  clnwq_pkg::work_item_t work,
  output logic                  result_valid,
  input  logic                  result_ready,
  output clnwq_pkg::out_item_t  result
);
  import clnwq_pkg::*;

  localparam int PW = $clog2(RING_ENTRIES);

  localparam logic [2:0] SEQ_IDLE     = 3'd0;
  localparam logic [2:0] SEQ_PUT_HI   = 3'd1;
  localparam logic [2:0] SEQ_PULSE_HI = 3'd2;
  localparam logic [2:0] SEQ_PUT_LO   = 3'd3;
  localparam logic [2:0] SEQ_PULSE_LO = 3'd4;

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] i);
    ring_next = (i == PW'(RING_ENTRIES - 1)) ? '0 : i + PW'(1);
  endfunction

  logic [PW-1:0] ring_head, ring_head_next;
  logic [PW-1:0] ring_tail, ring_tail_next;
  logic [2:0]    seq_state, seq_state_next;
  logic [7:0]    current_byte, current_byte_next;
  logic          current_is_data, current_is_data_next;
  logic [3:0]    wait_count, wait_count_next;
  logic          rs_level, rs_level_next;
  logic          e_level, e_level_next;
  logic [3:0]    nibble_level, nibble_level_next;
  logic          dropped_next;
  logic [PW:0]   pending;

  logic          fire;
  logic          wr_en;
  logic [PW-1:0] rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  logic          bypass_hit;
  ring_entry_t   bypass_data;
  ring_entry_t   tail_entry;
  logic [PW-1:0] head_plus;

  assign fire       = work_valid && (!result_valid || result_ready);
  assign work_ready = fire;

  // The entry at the tail is always read ahead, so a pop needs no wait.
  // A write to the address being read is forwarded around the RAM.
  assign tail_entry = bypass_hit ? bypass_data : ring_entry_t'(rd_data);
  assign rd_addr    = fire ? ring_tail_next : ring_tail;
  assign head_plus  = ring_next(ring_head);

  always_comb begin
    ring_head_next       = ring_head;
    ring_tail_next       = ring_tail;
    seq_state_next       = seq_state;
    current_byte_next    = current_byte;
    current_is_data_next = current_is_data;
    wait_count_next      = wait_count;
    rs_level_next        = rs_level;
    e_level_next         = e_level;
    nibble_level_next    = nibble_level;
    dropped_next         = 1'b0;
    wr_en                = 1'b0;
    if (work.is_enqueue) begin
      if (head_plus == ring_tail) begin
        dropped_next = 1'b1;
      end else begin
        wr_en          = fire;
        ring_head_next = head_plus;
      end
    end else if (wait_count != 4'd0) begin
      wait_count_next = wait_count - 4'd1;
    end else begin
      case (seq_state)
        SEQ_IDLE: begin
          if (ring_tail != ring_head) begin
            current_byte_next    = tail_entry.byte_value;
            current_is_data_next = tail_entry.is_data;
            ring_tail_next       = ring_next(ring_tail);
            rs_level_next        = tail_entry.is_data;
            seq_state_next       = SEQ_PUT_HI;
          end
        end
        SEQ_PUT_HI: begin
          nibble_level_next = current_byte[7:4];
          e_level_next      = 1'b1;
          wait_count_next   = cfg.pulse_wait_ticks;
          seq_state_next    = SEQ_PULSE_HI;
        end
        SEQ_PULSE_HI: begin
          e_level_next    = 1'b0;
          wait_count_next = cfg.pulse_wait_ticks;
          seq_state_next  = SEQ_PUT_LO;
        end
        SEQ_PUT_LO: begin
          nibble_level_next = current_byte[3:0];
          e_level_next      = 1'b1;
          wait_count_next   = cfg.pulse_wait_ticks;
          seq_state_next    = SEQ_PULSE_LO;
        end
        SEQ_PULSE_LO: begin
          e_level_next = 1'b0;
          // Clear and home need a longer settle time on the display.
          if (!current_is_data &&
              (current_byte == LCD_CLEAR || current_byte == LCD_HOME)) begin
            wait_count_next = cfg.slow_command_wait_ticks;
          end
          seq_state_next = SEQ_IDLE;
        end
        default: begin
          seq_state_next = SEQ_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    if (ring_head_next >= ring_tail_next) begin
      pending = {1'b0, ring_head_next} - {1'b0, ring_tail_next};
    end else begin
      pending = {1'b0, ring_head_next} + (PW + 1)'(RING_ENTRIES) - {1'b0, ring_tail_next};
    end
  end

  clnwq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RING_ENTRIES)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (ring_head),
    .wr_data (work.entry),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    bypass_hit  <= wr_en && (ring_head == rd_addr);
    bypass_data <= work.entry;
    if (fire) begin
      result.reg_select    <= rs_level_next;
      result.enable_pin    <= e_level_next;
      result.data_nibble   <= nibble_level_next;
      result.dropped       <= dropped_next;
      result.pending_count <= 5'(pending);
    end
    if (rst) begin
      ring_head       <= '0;
      ring_tail       <= '0;
      seq_state       <= SEQ_IDLE;
      current_byte    <= 8'd0;
      current_is_data <= 1'b0;
      wait_count      <= 4'd0;
      rs_level        <= 1'b0;
      e_level         <= 1'b0;
      nibble_level    <= 4'd0;
      result_valid    <= 1'b0;
    end else begin
      if (fire) begin
        ring_head       <= ring_head_next;
        ring_tail       <= ring_tail_next;
        seq_state       <= seq_state_next;
        current_byte    <= current_byte_next;
        current_is_data <= current_is_data_next;
        wait_count      <= wait_count_next;
        rs_level        <= rs_level_next;
        e_level         <= e_level_next;
        nibble_level    <= nibble_level_next;
        result_valid    <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

@@ src/char_lcd_nibble_write_queue_core.sv @@
// Top level of the character-LCD nibble write queue.
// Depends on clnwq_pkg, clnwq_front, clnwq_back and clnwq_ram.
//
// Each item on the input channel (item_valid/item_ready/item) is either a
// one-millisecond tick or an enqueue of a display write (a byte plus a
// command/data flag). Every item produces exactly one result item on the
// output channel (result_valid/result_ready/result) with the RS, E and
// D4..D7 pin levels, a dropped flag for an enqueue that found the ring full,
// and the number of writes waiting in the ring.
// The front part takes an item into a two-entry queue when it is offered;
// the back part then executes it from that queue into a result register,
// and result_valid stays high until the receiver takes the result. The
// sustained rate is one item per cycle while the receiver does not stall,
// set by the single ring and sequencer update the back part does each
// cycle. The ring is a RAM with a registered read; the entry at the tail
// is read ahead so a pop need not wait for the read.
// When the receiver stalls, the result register holds its item, the back
// part stops, and the front queue fills; item_ready falls once it is full.
// Synchronous reset empties the ring and the queue, returns the sequencer to
// idle with all pins low, and loads the wait registers with 1 and 2 ticks.
// The ring contents are not cleared; the pointers alone define what is valid.
// The APB port holds pulse_wait_ticks at address 0 and
// slow_command_wait_ticks at address 4; pready is always high.
module char_lcd_nibble_write_queue_core #(
  parameter int RING_ENTRIES = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  clnwq_pkg::in_item_t  item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output clnwq_pkg::out_item_t result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import clnwq_pkg::*;

  cfg_t       cfg;
  logic       work_valid;
  logic       work_ready;
  work_item_t work;
  logic       cfg_write;

  // Configuration registers. Address bit 2 selects the register.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_wait_ticks        <= PULSE_WAIT_RESET;
      cfg.slow_command_wait_ticks <= SLOW_WAIT_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_PULSE_WAIT) begin
        cfg.pulse_wait_ticks <= pwdata[3:0];
      end else begin
        cfg.slow_command_wait_ticks <= pwdata[3:0];
      end
    end
  end

  always_comb begin
    case (paddr[2])
      REG_PULSE_WAIT: prdata = {28'd0, cfg.pulse_wait_ticks};
      REG_SLOW_WAIT:  prdata = {28'd0, cfg.slow_command_wait_ticks};
      default:        prdata = 32'd0;
    endcase
  end

  clnwq_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .work_valid (work_valid),
    .work_ready (work_ready),
    .work       (work)
  );

  clnwq_back #(
    .RING_ENTRIES (RING_ENTRIES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .work_valid   (work_valid),
    .work_ready   (work_ready),
    .work         (work),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
